[rtl/srank_pkg.sv]
// Shared constants and types for the stable rank engine.
`timescale 1ns / 1ps
`default_nettype none

package srank_pkg;

    // Width of one input value.
    localparam int DATA_W = 32;
    // Width of the reported position and rank fields.
    localparam int POS_W = 6;
    // Output tdata width: position and rank, padded to whole bytes.
    localparam int OUT_TDATA_W = ((2 * POS_W + 7) / 8) * 8;
    // Default capacity of the cell chain.
    localparam int MAX_ITEMS_DEF = 64;

    // Phases of one set: loading values, circulating them, and reporting.
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROTATE,
        ST_EMIT
    } srank_state_t;

    // Commands that the controller broadcasts to every cell.
    typedef struct packed {
        logic rotate;
        logic emit_shift;
        logic clear;
    } srank_ctl_t;

endpackage

`default_nettype wire

[rtl/srank_cell.sv]
// One cell of the ranking chain: a held value, its rank and a circulating copy.
`timescale 1ns / 1ps
`default_nettype none

module srank_cell #(
    parameter int IDX_W = 6
) (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  srank_pkg::srank_ctl_t                   ctl,
    input  wire                                     load,
    input  wire  [IDX_W-1:0]                        cell_idx,
    input  wire  signed [srank_pkg::DATA_W-1:0]     load_value,
    input  wire  signed [srank_pkg::DATA_W-1:0]     pass_value_in,
    input  wire  [IDX_W-1:0]                        pass_idx_in,
    input  wire                                     pass_valid_in,
    input  wire  [IDX_W-1:0]                        rank_in,
    output logic signed [srank_pkg::DATA_W-1:0]     pass_value_out,
    output logic [IDX_W-1:0]                        pass_idx_out,
    output logic                                    pass_valid_out,
    output logic [IDX_W-1:0]                        rank_out
);

    logic signed [srank_pkg::DATA_W-1:0] own_value_reg, own_value_next;
    logic                                own_valid_reg, own_valid_next;
    logic [IDX_W-1:0]                    rank_reg, rank_next;
    logic signed [srank_pkg::DATA_W-1:0] pass_value_reg, pass_value_next;
    logic [IDX_W-1:0]                    pass_idx_reg, pass_idx_next;
    logic                                pass_valid_reg, pass_valid_next;
    logic                                pass_before;

    // The passing value sorts ahead of ours: smaller, or equal and earlier.
    assign pass_before = (pass_value_reg < own_value_reg) ||
                         ((pass_value_reg == own_value_reg) && (pass_idx_reg < cell_idx));

    always_comb
    begin
        own_value_next  = own_value_reg;
        own_valid_next  = own_valid_reg;
        rank_next       = rank_reg;
        pass_value_next = pass_value_reg;
        pass_idx_next   = pass_idx_reg;
        pass_valid_next = pass_valid_reg;
        if (ctl.clear)
        begin
            own_valid_next  = 1'b0;
            pass_valid_next = 1'b0;
        end
        else if (load)
        begin
            own_value_next  = load_value;
            own_valid_next  = 1'b1;
            rank_next       = '0;
            pass_value_next = load_value;
            pass_idx_next   = cell_idx;
            pass_valid_next = 1'b1;
        end
        else if (ctl.rotate)
        begin
            if (own_valid_reg && pass_valid_reg && pass_before)
            begin
                rank_next = rank_reg + IDX_W'(1);
            end
            pass_value_next = pass_value_in;
            pass_idx_next   = pass_idx_in;
            pass_valid_next = pass_valid_in;
        end
        else if (ctl.emit_shift)
        begin
            rank_next = rank_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_valid_reg  <= 1'b0;
            pass_valid_reg <= 1'b0;
        end
        else
        begin
            own_valid_reg  <= own_valid_next;
            pass_valid_reg <= pass_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        own_value_reg  <= own_value_next;
        rank_reg       <= rank_next;
        pass_value_reg <= pass_value_next;
        pass_idx_reg   <= pass_idx_next;
    end

    assign pass_value_out = pass_value_reg;
    assign pass_idx_out   = pass_idx_reg;
    assign pass_valid_out = pass_valid_reg;
    assign rank_out       = rank_reg;

endmodule

`default_nettype wire

[rtl/stable_rank_engine.sv]
// Top level of the stable rank engine: controller and the chain of ranking cells.
`timescale 1ns / 1ps
`default_nettype none

// Values are taken one per cycle while loading; the transaction marked last ends the set.
// After it, the circulating ring runs the ranking phase, then results leave one per cycle
// while m_tready is high, n results for a set of n held values.
// The ring length of the cell chain sets the length of the ranking phase.
// rst_n clears all valid bits, counters and the overflow flag; no clearing pass is needed.

module stable_rank_engine #(
    parameter int MAX_ITEMS = srank_pkg::MAX_ITEMS_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // Input stream.
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [srank_pkg::DATA_W-1:0]        s_tdata,   // [31:0] value
    input  wire                                 s_tlast,   // last value of the set
    // Result stream.
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [srank_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [5:0] position, [11:6] rank
    output logic                                m_tuser,   // [0] overflow
    output logic                                m_tlast    // final result of the set
);

    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    srank_pkg::srank_state_t state_reg, state_next;
    srank_pkg::srank_ctl_t   ctl;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             overflow_reg, overflow_next;
    logic [IDX_W-1:0] rot_cnt_reg, rot_cnt_next;
    logic [IDX_W-1:0] out_pos_reg, out_pos_next;

    logic in_fire;
    logic out_fire;
    logic store_full;
    logic rot_done;
    logic final_res;

    // Chain wiring: the circulating copies form a ring, ranks shift toward cell 0.
    logic signed [srank_pkg::DATA_W-1:0] pass_value_w [MAX_ITEMS];
    logic [IDX_W-1:0]                    pass_idx_w   [MAX_ITEMS];
    logic                                pass_valid_w [MAX_ITEMS];
    logic [IDX_W-1:0]                    rank_w       [MAX_ITEMS];

    assign in_fire    = s_tvalid && s_tready;
    assign out_fire   = m_tvalid && m_tready;
    assign store_full = (count_reg == CNT_W'(MAX_ITEMS));
    assign rot_done   = (rot_cnt_reg == IDX_W'(MAX_ITEMS - 1));
    // The result at position count - 1 closes the set.
    assign final_res  = ((CNT_W'(out_pos_reg) + CNT_W'(1)) == count_reg);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srank_pkg::ST_LOAD:
            begin
                if (in_fire && s_tlast)
                begin
                    state_next = srank_pkg::ST_ROTATE;
                end
            end
            srank_pkg::ST_ROTATE:
            begin
                if (rot_done)
                begin
                    state_next = srank_pkg::ST_EMIT;
                end
            end
            srank_pkg::ST_EMIT:
            begin
                if (out_fire && final_res)
                begin
                    state_next = srank_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = srank_pkg::ST_LOAD;
            end
        endcase
    end

    // Output and command decode.
    always_comb
    begin
        s_tready       = 1'b0;
        m_tvalid       = 1'b0;
        ctl.rotate     = 1'b0;
        ctl.emit_shift = 1'b0;
        ctl.clear      = 1'b0;
        unique case (state_reg)
            srank_pkg::ST_LOAD:
            begin
                s_tready = 1'b1;
            end
            srank_pkg::ST_ROTATE:
            begin
                ctl.rotate = 1'b1;
            end
            srank_pkg::ST_EMIT:
            begin
                m_tvalid       = 1'b1;
                ctl.emit_shift = m_tready;
                ctl.clear      = m_tready && final_res;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Counters and the overflow flag.
    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        rot_cnt_next  = rot_cnt_reg;
        out_pos_next  = out_pos_reg;
        if (in_fire)
        begin
            // A value arriving at a full store is dropped but still may end the set.
            if (store_full)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
            rot_cnt_next = '0;
            out_pos_next = '0;
        end
        if (ctl.rotate)
        begin
            rot_cnt_next = rot_cnt_reg + IDX_W'(1);
        end
        if (out_fire)
        begin
            out_pos_next = out_pos_reg + IDX_W'(1);
            if (final_res)
            begin
                count_next    = '0;
                overflow_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= srank_pkg::ST_LOAD;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            rot_cnt_reg  <= '0;
            out_pos_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            rot_cnt_reg  <= rot_cnt_next;
            out_pos_reg  <= out_pos_next;
        end
    end

    // The chain. Arrival k lands in cell k, so results leave cell 0 in arrival order.
    for (genvar k = 0; k < MAX_ITEMS; k++)
    begin : g_cell
        localparam int PREV = (k == 0) ? MAX_ITEMS - 1 : k - 1;

        logic             load_k;
        logic [IDX_W-1:0] rank_in_k;

        assign load_k = in_fire && (count_reg == CNT_W'(k));

        if (k == MAX_ITEMS - 1)
        begin : g_tail
            assign rank_in_k = '0;
        end
        else
        begin : g_body
            assign rank_in_k = rank_w[k + 1];
        end

        srank_cell #(
            .IDX_W (IDX_W)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .ctl            (ctl),
            .load           (load_k),
            .cell_idx       (IDX_W'(k)),
            .load_value     ($signed(s_tdata)),
            .pass_value_in  (pass_value_w[PREV]),
            .pass_idx_in    (pass_idx_w[PREV]),
            .pass_valid_in  (pass_valid_w[PREV]),
            .rank_in        (rank_in_k),
            .pass_value_out (pass_value_w[k]),
            .pass_idx_out   (pass_idx_w[k]),
            .pass_valid_out (pass_valid_w[k]),
            .rank_out       (rank_w[k])
        );
    end

    // Result fields: position from the counter, rank from the head of the chain.
    always_comb
    begin
        m_tdata = '0;
        m_tdata[srank_pkg::POS_W-1:0] = srank_pkg::POS_W'(out_pos_reg);
        m_tdata[2*srank_pkg::POS_W-1:srank_pkg::POS_W] = srank_pkg::POS_W'(rank_w[0]);
    end

    assign m_tuser = overflow_reg;
    assign m_tlast = final_res;

endmodule

`default_nettype wire
